/* rtl/dkbf_pkg.sv */
// shared constants, codes and control structs for the dual-key best-fit take table
`timescale 1ns / 1ps
package dkbf_pkg;
    localparam int TABLE_ENTRIES = 64;
    localparam int ID_BITS       = 20;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int KEY_W         = 32;
    localparam int OUT_ID_W      = 20;
    localparam int STATUS_W      = 3;
    localparam int FUNC_W        = 2;
    localparam int ROW_W         = 2 * KEY_W + ID_BITS;

    localparam logic [FUNC_W-1:0] F_INSERT     = 2'd0;
    localparam logic [FUNC_W-1:0] F_TAKE_WEIGHT = 2'd1;
    localparam logic [FUNC_W-1:0] F_TAKE_VOLUME = 2'd2;

    localparam logic [STATUS_W-1:0] ST_TAKEN    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NONE     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_IDS_OUT  = 3'd4;

    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic skip;
        logic last;
        logic out_busy;
    } t_status;
endpackage

/* rtl/dkbf_ram.sv */
// generic single write, single read ram with registered read data
`timescale 1ns / 1ps
module dkbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/dkbf_ctrl.sv */
// controller state machine sequencing load, slot scan and commit
`timescale 1ns / 1ps
module dkbf_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  dkbf_pkg::t_status i_status,
    output dkbf_pkg::t_cmd    o_cmd
);
    import dkbf_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN, S_DONE} t_state;

    t_state r_state, n_state;
    logic   accept;

    assign o_stall = (r_state != S_IDLE);
    assign accept  = i_valid && (r_state == S_IDLE);

    always_comb begin
        o_cmd        = '0;
        o_cmd.load   = accept;
        o_cmd.scan   = (r_state == S_SCAN);
        o_cmd.commit = (r_state == S_DONE) && !i_status.out_busy;
        n_state      = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) n_state = i_status.skip ? S_DONE : S_SCAN;
            end
            S_SCAN: begin
                if (i_status.last) n_state = S_DRAIN;
            end
            S_DRAIN: n_state = S_DONE;
            S_DONE: begin
                if (!i_status.out_busy) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

/* rtl/dkbf_datapath.sv */
// slot storage, scan compare, id counter and output register
`timescale 1ns / 1ps
module dkbf_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  dkbf_pkg::t_cmd                      i_cmd,
    output dkbf_pkg::t_status                   o_status,
    input  logic [dkbf_pkg::FUNC_W-1:0]         i_func,
    input  logic signed [dkbf_pkg::KEY_W-1:0]   i_item_weight,
    input  logic signed [dkbf_pkg::KEY_W-1:0]   i_item_volume,
    input  logic signed [dkbf_pkg::KEY_W-1:0]   i_min_key,
    input  logic                                i_stall,
    output logic                                o_valid,
    output logic [dkbf_pkg::STATUS_W-1:0]       o_status_code,
    output logic [dkbf_pkg::OUT_ID_W-1:0]       o_item_id
);
    import dkbf_pkg::*;

    logic [TABLE_ENTRIES-1:0]  r_valid;
    logic [ID_BITS:0]          r_next_id;
    logic [FUNC_W-1:0]         r_func;
    logic signed [KEY_W-1:0]   r_weight, r_volume, r_min;
    logic [IDX_W-1:0]          r_idx, r_cmp_idx, r_best;
    logic                      r_cmp_v, r_found;
    logic signed [KEY_W-1:0]   r_best_key;
    logic [ID_BITS-1:0]        r_best_id;
    logic                      r_out_valid;
    logic [STATUS_W-1:0]       r_out_status;
    logic [OUT_ID_W-1:0]       r_out_id;

    logic [ROW_W-1:0]          rdata;
    logic signed [KEY_W-1:0]   row_w, row_v, key;
    logic [ID_BITS-1:0]        row_id;
    logic                      exhausted, is_insert, is_take, better, we;
    logic [OUT_ID_W+ID_BITS-1:0] id_wide_new, id_wide_best;

    assign exhausted = r_next_id[ID_BITS];
    assign is_insert = (r_func == F_INSERT);
    assign is_take   = (r_func == F_TAKE_WEIGHT) || (r_func == F_TAKE_VOLUME);

    assign row_w  = rdata[ROW_W-1 -: KEY_W];
    assign row_v  = rdata[ID_BITS +: KEY_W];
    assign row_id = rdata[ID_BITS-1:0];
    assign key    = (r_func == F_TAKE_VOLUME) ? row_v : row_w;

    always_comb begin
        better = 1'b0;
        if (is_insert) begin
            better = !r_valid[r_cmp_idx] && !r_found;
        end else if (r_valid[r_cmp_idx] && key >= r_min) begin
            better = !r_found || key < r_best_key ||
                     (key == r_best_key && row_id > r_best_id);
        end
    end

    assign we = i_cmd.commit && is_insert && !exhausted && r_found;

    assign id_wide_new  = {{OUT_ID_W{1'b0}}, r_next_id[ID_BITS-1:0]};
    assign id_wide_best = {{OUT_ID_W{1'b0}}, r_best_id};

    assign o_status.skip     = !((i_func == F_INSERT) && !exhausted) &&
                               !((i_func == F_TAKE_WEIGHT) || (i_func == F_TAKE_VOLUME));
    assign o_status.last     = (r_idx == IDX_W'(TABLE_ENTRIES - 1));
    assign o_status.out_busy = r_out_valid && i_stall;

    dkbf_ram #(
        .WIDTH (ROW_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_best),
        .i_wdata ({r_weight, r_volume, r_next_id[ID_BITS-1:0]}),
        .i_raddr (r_idx),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_next_id   <= '0;
            r_out_valid <= 1'b0;
            r_cmp_v     <= 1'b0;
            r_found     <= 1'b0;
            r_idx       <= '0;
        end else begin
            r_cmp_v <= i_cmd.scan;
            if (i_cmd.load) begin
                r_func   <= i_func;
                r_weight <= i_item_weight;
                r_volume <= i_item_volume;
                r_min    <= i_min_key;
                r_idx    <= '0;
                r_found  <= 1'b0;
            end
            if (i_cmd.scan) begin
                r_idx     <= r_idx + 1'b1;
                r_cmp_idx <= r_idx;
            end
            if (r_cmp_v && better) begin
                r_found    <= 1'b1;
                r_best     <= r_cmp_idx;
                r_best_key <= key;
                r_best_id  <= row_id;
            end
            if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
                r_out_id    <= '0;
                if (is_insert) begin
                    if (exhausted) begin
                        r_out_status <= ST_IDS_OUT;
                    end else if (r_found) begin
                        r_out_status     <= ST_INSERTED;
                        r_out_id         <= id_wide_new[OUT_ID_W-1:0];
                        r_valid[r_best]  <= 1'b1;
                        r_next_id        <= r_next_id + 1'b1;
                    end else begin
                        r_out_status <= ST_FULL;
                    end
                end else if (is_take && r_found) begin
                    r_out_status    <= ST_TAKEN;
                    r_out_id        <= id_wide_best[OUT_ID_W-1:0];
                    r_valid[r_best] <= 1'b0;
                end else begin
                    r_out_status <= ST_NONE;
                end
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status_code = r_out_status;
    assign o_item_id     = r_out_id;

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.scan && i_cmd.commit) && !(i_cmd.load && i_cmd.commit))
        else $error("scan or load overlaps commit");
    a_id_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next_id <= (ID_BITS+1)'(1) << ID_BITS)
        else $error("id counter beyond limit");
    a_insert_sets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we |=> r_valid[$past(r_best)])
        else $error("inserted slot not marked valid");
    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> !(r_out_valid && i_stall))
        else $error("commit over a waiting word");
endmodule

/* rtl/dual_key_best_fit_take_table.sv */
// top level of the dual-key best-fit take table
//
// input channel: i_valid / o_stall carry one word of i_func, i_item_weight,
// i_item_volume and i_min_key; a word is taken when i_valid is high and
// o_stall is low. output channel: o_valid / i_stall carry o_status and
// o_item_id, one result word per input word, in order.
// an insert or take walks every slot of the table through the ram read
// port, one slot a cycle, before its result is registered. an insert
// with ids exhausted or an unused func code skips the walk. one word is
// in work at a time; the next is accepted the cycle after the result is
// registered, even while that result still waits on i_stall.
// while i_stall holds a result, a finished word waits in its final state
// and the output word holds steady.
// synchronous active-low reset empties the table, clears the id counter
// and drops o_valid; no clearing pass is needed.
`timescale 1ns / 1ps
module dual_key_best_fit_take_table (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [dkbf_pkg::FUNC_W-1:0]         i_func,
    input  logic signed [dkbf_pkg::KEY_W-1:0]   i_item_weight,
    input  logic signed [dkbf_pkg::KEY_W-1:0]   i_item_volume,
    input  logic signed [dkbf_pkg::KEY_W-1:0]   i_min_key,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [dkbf_pkg::STATUS_W-1:0]       o_status,
    output logic [dkbf_pkg::OUT_ID_W-1:0]       o_item_id
);
    import dkbf_pkg::*;

    t_cmd    cmd;
    t_status status;

    dkbf_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    dkbf_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_func        (i_func),
        .i_item_weight (i_item_weight),
        .i_item_volume (i_item_volume),
        .i_min_key     (i_min_key),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_status_code (o_status),
        .o_item_id     (o_item_id)
    );
endmodule

/* verif/tb_top.sv */
// self-checking testbench for the dual-key best-fit take table
`timescale 1ns / 1ps
module tb_top;
    import dkbf_pkg::*;

    localparam logic [FUNC_W-1:0] F_UNUSED = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic [FUNC_W-1:0] i_func = F_INSERT;
    logic signed [KEY_W-1:0] i_item_weight = '0;
    logic signed [KEY_W-1:0] i_item_volume = '0;
    logic signed [KEY_W-1:0] i_min_key = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic [STATUS_W-1:0] o_status;
    logic [OUT_ID_W-1:0] o_item_id;

    dual_key_best_fit_take_table dut (.*);

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [OUT_ID_W-1:0] id;
    } t_reply;

    // predicted table
    logic                    tbl_used [TABLE_ENTRIES];
    logic signed [KEY_W-1:0] tbl_weight [TABLE_ENTRIES];
    logic signed [KEY_W-1:0] tbl_volume [TABLE_ENTRIES];
    logic [ID_BITS-1:0]      tbl_id [TABLE_ENTRIES];
    logic [ID_BITS:0]        id_count;

    t_reply reply_q [$];
    int     errors = 0;
    int     stall_mode = 0;

    initial forever #5 i_clk = ~i_clk;

    initial begin
        #20ms;
        $display("Some tests failed");
        $finish;
    end

    function automatic t_reply predict_word(logic [FUNC_W-1:0] f, logic signed [KEY_W-1:0] w,
                                            logic signed [KEY_W-1:0] v,
                                            logic signed [KEY_W-1:0] mk);
        t_reply r;
        int best;
        logic signed [KEY_W-1:0] k, bk;
        r.status = ST_NONE;
        r.id = '0;
        best = -1;
        bk = '0;
        if (f == F_INSERT) begin
            if (id_count[ID_BITS]) begin
                r.status = ST_IDS_OUT;
            end else begin
                r.status = ST_FULL;
                for (int i = 0; i < TABLE_ENTRIES; i++) begin
                    if (!tbl_used[i]) begin
                        tbl_used[i] = 1'b1;
                        tbl_weight[i] = w;
                        tbl_volume[i] = v;
                        tbl_id[i] = id_count[ID_BITS-1:0];
                        r.status = ST_INSERTED;
                        r.id = OUT_ID_W'(id_count);
                        id_count++;
                        break;
                    end
                end
            end
        end else if (f == F_TAKE_WEIGHT || f == F_TAKE_VOLUME) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                if (tbl_used[i]) begin
                    k = (f == F_TAKE_VOLUME) ? tbl_volume[i] : tbl_weight[i];
                    if (k >= mk && (best < 0 || k < bk ||
                        (k == bk && tbl_id[i] > tbl_id[best]))) begin
                        best = i;
                        bk = k;
                    end
                end
            end
            if (best >= 0) begin
                tbl_used[best] = 1'b0;
                r.status = ST_TAKEN;
                r.id = OUT_ID_W'(tbl_id[best]);
            end
        end
        return r;
    endfunction

    // receiver: stall pattern, checking at the rising edge
    always @(negedge i_clk) begin
        case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 3) == 0);
            default: i_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    always @(posedge i_clk) begin
        t_reply got, exp_r;
        if (i_rst_n && o_valid && !i_stall) begin
            got.status = o_status;
            got.id = o_item_id;
            if (reply_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected word %0d %0d", o_status, o_item_id);
            end else begin
                exp_r = reply_q.pop_front();
                if (got !== exp_r) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: expected %0d/%0d got %0d/%0d",
                                 exp_r.status, exp_r.id, got.status, got.id);
                end
            end
        end
    end

    task automatic send_word(logic [FUNC_W-1:0] f, logic signed [KEY_W-1:0] w,
                             logic signed [KEY_W-1:0] v, logic signed [KEY_W-1:0] mk);
        i_valid <= 1'b1;
        i_func <= f;
        i_item_weight <= w;
        i_item_volume <= v;
        i_min_key <= mk;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        reply_q.push_back(predict_word(f, w, v, mk));
        @(negedge i_clk);
    endtask

    task automatic pause_sender();
        i_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge i_clk);
    endtask

    function automatic logic signed [KEY_W-1:0] rand_key();
        case ($urandom_range(0, 4))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return KEY_W'($urandom);
            default: return KEY_W'($signed($urandom_range(0, 15)) - 8);
        endcase
    endfunction

    task automatic test_directed();
        send_word(F_TAKE_WEIGHT, 0, 0, 32'sh80000000);
        send_word(F_INSERT, 32'sh7fffffff, 32'sh80000000, 0);
        send_word(F_INSERT, 32'sh80000000, 32'sh7fffffff, 0);
        send_word(F_INSERT, 5, 5, 0);
        send_word(F_INSERT, 5, -1, 0);
        send_word(F_UNUSED, 32'shffffffff, 32'shffffffff, 32'shffffffff);
        send_word(F_TAKE_WEIGHT, 0, 0, 32'sh7fffffff);
        send_word(F_TAKE_WEIGHT, 0, 0, 32'sh7fffffff);
        send_word(F_TAKE_WEIGHT, 0, 0, 4);
        send_word(F_TAKE_VOLUME, 0, 0, -1);
        send_word(F_TAKE_VOLUME, 0, 0, 32'sh80000000);
        send_word(F_TAKE_VOLUME, 0, 0, 32'sh80000000);
        send_word(F_TAKE_WEIGHT, 0, 0, 32'sh80000000);
        pause_sender();
    endtask

    task automatic test_table_full();
        for (int i = 0; i < TABLE_ENTRIES + 2; i++) send_word(F_INSERT, i, -i, 0);
        send_word(F_TAKE_VOLUME, 0, 0, -3);
        send_word(F_INSERT, 1, 1, 0);
        send_word(F_INSERT, 1, 1, 0);
        for (int i = 0; i < TABLE_ENTRIES; i++) send_word(F_TAKE_WEIGHT, 0, 0, 32'sh80000000);
        pause_sender();
    endtask

    task automatic test_random(int n);
        int burst;
        logic [FUNC_W-1:0] f;
        while (n > 0) begin
            stall_mode = $urandom_range(0, 2);
            burst = $urandom_range(1, 20);
            repeat (burst) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: f = F_INSERT;
                    4, 5, 6: f = F_TAKE_WEIGHT;
                    7, 8: f = F_TAKE_VOLUME;
                    default: f = F_UNUSED;
                endcase
                send_word(f, rand_key(), rand_key(), rand_key());
                n--;
            end
            if ($urandom_range(0, 2) != 0) pause_sender();
        end
        i_valid <= 1'b0;
    endtask

    initial begin
        for (int i = 0; i < TABLE_ENTRIES; i++) tbl_used[i] = 1'b0;
        id_count = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_table_full();
        test_random(550);
        while (reply_q.size() != 0) @(posedge i_clk);
        stall_mode = 0;
        repeat (200) @(posedge i_clk);
        if (errors == 0 && reply_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
